// ----- hdl/bte_pkg.sv -----
package bte_pkg;

  localparam int RateFracBits = 16;
  localparam int CountBits    = 16;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_CHECK_INTERVAL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INIT_DISCHARGE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_INIT_CHARGE    = 2'd2;

  localparam logic [CountBits-1:0] COUNT_MAX = {CountBits{1'b1}};
  localparam logic [23:0] TIME_MAX = 24'hFFFFFF;

  // restoring divider: 64-bit dividend, 33-bit divisor
  localparam int DivSteps = 64;
  localparam int DivCntW  = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE_DIV,
    ST_RATE_END,
    ST_MEAN_DIV,
    ST_MEAN_END,
    ST_DRIFT,
    ST_TIME_DIV,
    ST_TIME_END,
    ST_OUT
  } bte_state_t;

endpackage

// ----- hdl/bte_divider.sv -----
module bte_divider
  import bte_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  dividend,
  input  logic [32:0]  divisor,
  output logic         done,
  output logic [63:0]  quotient
);

  logic [63:0]        q_r, q_nxt;
  logic [32:0]        rem_r, rem_nxt;
  logic [32:0]        den_r, den_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [33:0]        trial;
  logic [34:0]        diff;

  // one quotient bit a cycle
  always_comb begin
    trial    = {rem_r, q_r[63]};
    diff     = {1'b0, trial} - {2'b00, den_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below the divisor, so 33 bits hold it
      if (!diff[34]) begin
        rem_nxt = diff[32:0];
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[32:0];
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DivCntW'(DivSteps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("divider start lost");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r < DivCntW'(DivSteps)) else $error("divider count overrun");

endmodule

// ----- hdl/battery_time_estimator_core.sv -----
// from the accepting edge to out_tvalid: three divisions (rate, mean step, time) when a
//   present rate is found, two (rate, time) otherwise, plus the sequencing states
// throughput: one item at a time; the next item is taken only once the result has left,
//   which waits for out_tready
// rst_n is synchronous, active low: config to reset values, estimator state cleared
// the rate is set by the shared restoring divider, one quotient bit a cycle
module battery_time_estimator_core
  import bte_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,   // percent[6:0], prev_percent[13:7], zeros
  input  logic                in_tuser,   // on_battery
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [55:0]         out_tdata,  // time_left[23:0], saved_rate[55:24]
  output logic                out_tuser   // rate_saved
);

  bte_state_t state_r, state_nxt;

  // configuration
  logic [11:0] check_interval_r;

  // estimator state
  logic [6:0]  begin_r, end_r;
  logic [31:0] elapsed_r, span_r;
  logic [31:0] dmean_r, cmean_r, dsaved_r, csaved_r;
  logic [CountBits-1:0] dcnt_r, ccnt_r;

  // per item working registers
  logic [6:0]  pct_r;
  logic        batt_r;
  logic [31:0] rate_r;
  logic        up_r;     // rate at or above mean; later, whether a time estimate applies
  logic        refr_r;
  logic [23:0] time_r;
  logic [31:0] osaved_r;
  logic        in_prev_ok_r;

  // divider
  logic        div_start;
  logic [63:0] div_a;
  logic [32:0] div_b;
  logic        div_done;
  logic [63:0] div_q;

  bte_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  logic [6:0]  in_pct, in_prev;
  logic        accept;
  logic [6:0]  new_begin, new_end;
  logic [31:0] new_elapsed, new_span;
  logic [6:0]  pdiff;
  logic [31:0] cur_mean, cur_saved;
  logic [CountBits-1:0] cur_cnt;
  logic        rate_up;
  logic [32:0] mdist;
  logic [32:0] dcount;
  logic [31:0] new_mean;
  logic [31:0] dev;
  logic [38:0] dev100;
  logic [31:0] use_rate;
  logic [6:0]  tnum;

  assign in_pct  = in_tdata[6:0];
  assign in_prev = in_tdata[13:7];
  assign accept  = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);

  // point and span update of the sample
  always_comb begin
    new_begin   = begin_r;
    new_end     = end_r;
    new_elapsed = elapsed_r;
    new_span    = span_r;
    if (in_prev != 7'd0) begin
      if (begin_r != 7'd0) new_elapsed = elapsed_r + {20'd0, check_interval_r};
      if (in_prev != in_pct) begin
        if (begin_r == 7'd0) begin
          new_begin   = in_pct;
          new_elapsed = '0;
          new_span    = '0;
        end else begin
          new_end  = in_pct;
          new_span = new_elapsed;
        end
      end
    end
  end

  assign pdiff = (new_end > new_begin) ? new_end - new_begin : new_begin - new_end;

  assign cur_mean  = batt_r ? dmean_r  : cmean_r;
  assign cur_saved = batt_r ? dsaved_r : csaved_r;
  assign cur_cnt   = batt_r ? dcnt_r   : ccnt_r;
  assign rate_up   = (rate_r >= cur_mean);
  assign mdist     = rate_up ? {1'b0, rate_r} - {1'b0, cur_mean}
                             : {1'b0, cur_mean} - {1'b0, rate_r};
  assign dcount    = {{(33-CountBits){1'b0}}, cur_cnt} + 33'd1;
  assign new_mean  = up_r ? cur_mean + div_q[31:0] : cur_mean - div_q[31:0];
  assign dev       = (cur_saved > cur_mean) ? cur_saved - cur_mean : cur_mean - cur_saved;
  assign dev100    = {7'd0, dev} * 39'd100;
  assign use_rate  = (rate_r != 32'd0) ? rate_r : cur_saved;
  assign tnum      = batt_r ? pct_r : 7'd100 - pct_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (accept) state_nxt = ST_RATE_DIV;
      ST_RATE_DIV: if (div_done) state_nxt = ST_RATE_END;
      ST_RATE_END: state_nxt = (rate_r != 32'd0) ? ST_MEAN_DIV : ST_DRIFT;
      ST_MEAN_DIV: if (div_done) state_nxt = ST_MEAN_END;
      ST_MEAN_END: state_nxt = ST_DRIFT;
      ST_DRIFT:    state_nxt = ST_TIME_DIV;
      ST_TIME_DIV: if (div_done) state_nxt = ST_TIME_END;
      ST_TIME_END: state_nxt = ST_OUT;
      ST_OUT:      if (out_tready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // divider launches; zero divisors are replaced and the quotient ignored
  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    div_b     = 33'd1;
    case (state_r)
      ST_IDLE: begin
        div_start = accept;
        div_a     = 64'({9'd0, pdiff} * 16'd36) << RateFracBits;
        div_b     = (new_span == 32'd0) ? 33'd1 : {1'b0, new_span};
      end
      ST_RATE_END: begin
        // rounding up the step when the mean falls
        div_start = (rate_r != 32'd0);
        div_a     = 64'(mdist) + 64'(dcount) - (rate_up ? 64'(dcount) : 64'd1);
        div_b     = dcount;
      end
      ST_DRIFT: begin
        div_start = 1'b1;
        div_a     = 64'({9'd0, tnum} * 16'd36) << RateFracBits;
        div_b     = (use_rate == 32'd0) ? 33'd1 : {1'b0, use_rate};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      check_interval_r <= 12'd10;
      begin_r <= '0;  end_r <= '0;
      elapsed_r <= '0;  span_r <= '0;
      dmean_r <= '0;  cmean_r <= '0;  dsaved_r <= '0;  csaved_r <= '0;
      dcnt_r <= '0;  ccnt_r <= '0;
      rate_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHECK_INTERVAL: check_interval_r <= cfg_data[11:0];
          CFG_INIT_DISCHARGE: begin
            dmean_r <= cfg_data;  dsaved_r <= cfg_data;
          end
          CFG_INIT_CHARGE: begin
            cmean_r <= cfg_data;  csaved_r <= cfg_data;
          end
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: if (accept) begin
          begin_r   <= new_begin;
          end_r     <= new_end;
          elapsed_r <= new_elapsed;
          span_r    <= new_span;
          pct_r     <= in_pct;
          batt_r    <= in_tuser;
          refr_r    <= 1'b0;
          // zero rate when no previous sample, no end point or no span
          rate_r    <= '0;
        end
        ST_RATE_DIV: if (div_done) begin
          if (in_prev_ok_r && end_r != 7'd0 && span_r != 32'd0)
            rate_r <= (div_q[63:32] != 32'd0) ? 32'hFFFF_FFFF : div_q[31:0];
        end
        ST_RATE_END: up_r <= rate_up;
        ST_MEAN_END: begin
          if (batt_r) begin
            dmean_r <= new_mean;
            if (dcnt_r != COUNT_MAX) dcnt_r <= dcnt_r + 1'b1;
          end else begin
            cmean_r <= new_mean;
            if (ccnt_r != COUNT_MAX) ccnt_r <= ccnt_r + 1'b1;
          end
          refr_r <= 1'b1;  // provisional, settled in drift step
        end
        ST_DRIFT: begin
          if (refr_r) begin
            if (cur_saved == 32'd0 || dev100 > {7'd0, cur_saved}) begin
              if (batt_r) dsaved_r <= cur_mean; else csaved_r <= cur_mean;
              osaved_r <= cur_mean;
            end else begin
              refr_r   <= 1'b0;
              osaved_r <= cur_saved;
            end
          end else begin
            osaved_r <= cur_saved;
          end
          up_r <= (pct_r < 7'd100) && (use_rate != 32'd0);
        end
        ST_TIME_END: begin
          if (!up_r) time_r <= '0;
          else time_r <= (div_q[63:24] != 40'd0) ? TIME_MAX : div_q[23:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_prev_ok_r <= (in_prev != 7'd0);
  end

  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {osaved_r, time_r};
  assign out_tuser  = refr_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("input taken while busy");
  a_out_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> state_r == ST_IDLE) else $error("result not retired");
  a_counts_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MEAN_END && batt_r && dcnt_r == COUNT_MAX) |=> dcnt_r == COUNT_MAX)
    else $error("sample count wrapped");

endmodule
